FILE: hdl/csa_pkg.sv
// Shared types and constants for the contiguous slot allocator.
// No dependencies; every other file imports this package.
package csa_pkg;

  localparam int SLOT_W  = 12;   // slot index
  localparam int END_W   = 13;   // slot end, holds the pool size itself
  localparam int LEN_W   = 8;    // run length stored at a run head
  localparam int NEED_W  = 9;    // slots asked for, before the run limit check
  localparam int VC_W    = 18;
  localparam int VPS_SHIFT = 10; // vertices per slot is a power of two
  localparam int DRAW_W  = 10;
  localparam int CNT_W   = 11;

  localparam logic [END_W-1:0]  NUM_SLOTS     = 13'd4096;
  localparam logic [NEED_W-1:0] MAX_RUN_SLOTS = 9'd255;
  localparam logic [CNT_W-1:0]  MAX_DRAWS     = 11'd1024;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NO_DRAW  = 2'd2;

  typedef struct packed {
    logic             used;
    logic [LEN_W-1:0] len;
  } slot_ent_t;

  typedef struct packed {
    logic              take;
    logic              give;
    logic              pool;
    logic [DRAW_W-1:0] data;
  } pool_cmd_t;

endpackage

FILE: hdl/csa_req_if.sv
// Request channel of the slot allocator: valid/ready plus the request fields.
// Depends on csa_pkg for field widths.
interface csa_req_if;
  import csa_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic              pool;
  logic [VC_W-1:0]   vertex_count;
  logic [SLOT_W-1:0] start_slot;
  logic [DRAW_W-1:0] draw_index;

  modport source (output valid, op, pool, vertex_count, start_slot, draw_index,
                  input ready);
  modport sink (input valid, op, pool, vertex_count, start_slot, draw_index,
                output ready);
endinterface

FILE: hdl/csa_rsp_if.sv
// Response channel of the slot allocator: valid/ready plus the result fields.
// Depends on csa_pkg for field widths.
interface csa_rsp_if;
  import csa_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [SLOT_W-1:0] slot_out;
  logic [DRAW_W-1:0] draw_out;
  logic              relocated;
  logic [END_W-1:0]  used_end;
  logic [CNT_W-1:0]  draw_total;

  modport source (output valid, status, slot_out, draw_out, relocated, used_end,
                  draw_total, input ready);
  modport sink (input valid, status, slot_out, draw_out, relocated, used_end,
                draw_total, output ready);
endinterface

FILE: hdl/csa_draw_pool.sv
// Draw index pools: per pool a queue of freed indices and a counter of fresh ones.
// Depends on csa_pkg. Taken index appears on take_data the cycle after take.
module csa_draw_pool (
  input  logic                                  clk,
  input  logic                                  rst,
  input  csa_pkg::pool_cmd_t                    cmd,
  output logic [1:0]                            avail,
  output logic [csa_pkg::DRAW_W-1:0]            take_data,
  output logic [1:0][csa_pkg::CNT_W-1:0]        total
);
  import csa_pkg::*;

  logic [DRAW_W-1:0] fifo_o [MAX_DRAWS];
  logic [DRAW_W-1:0] fifo_w [MAX_DRAWS];
  logic [DRAW_W-1:0] rd  [2];
  logic [CNT_W-1:0]  cnt [2];
  logic [CNT_W-1:0]  ctr [2];
  logic [DRAW_W-1:0] q_o, q_w, ctr_snap;
  logic              sel_fifo, sel_pool;
  logic [DRAW_W-1:0] wa;
  logic              do_give;

  assign wa      = rd[cmd.pool] + cnt[cmd.pool][DRAW_W-1:0];
  assign do_give = cmd.give && (cnt[cmd.pool] != MAX_DRAWS);

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      avail[p] = (cnt[p] != '0) || (ctr[p] < MAX_DRAWS);
      total[p] = ctr[p];
    end
  end

  assign take_data = sel_fifo ? (sel_pool ? q_w : q_o) : ctr_snap;

  always_ff @(posedge clk) begin
    if (do_give && !cmd.pool) fifo_o[wa] <= cmd.data;
    if (do_give && cmd.pool) fifo_w[wa] <= cmd.data;
    q_o <= fifo_o[rd[0]];
    q_w <= fifo_w[rd[1]];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sel_pool <= cmd.pool;
      ctr_snap <= ctr[cmd.pool][DRAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < 2; p++) begin
        rd[p]  <= '0;
        cnt[p] <= '0;
        ctr[p] <= '0;
      end
      sel_fifo <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (cnt[cmd.pool] != '0) begin
          rd[cmd.pool]  <= rd[cmd.pool] + 1'b1;
          cnt[cmd.pool] <= cnt[cmd.pool] - 1'b1;
          sel_fifo      <= 1'b1;
        end else begin
          ctr[cmd.pool] <= ctr[cmd.pool] + 1'b1;
          sel_fifo      <= 1'b0;
        end
      end else if (do_give) begin
        cnt[cmd.pool] <= cnt[cmd.pool] + 1'b1;
      end
    end
  end

endmodule

FILE: hdl/contiguous_slot_allocator.sv
// First-fit contiguous slot allocator over 4096 slots with two draw index pools.
// After reset the slot table is cleared one entry a cycle, with req.ready low.
// One request is handled at a time by a sequencer around one read port and one
// write port of the slot table: allocate scans for the first free run, takes a
// draw index and marks the run; free releases the run, gives its draw index back
// and trims the used end; update keeps, shrinks or extends the run in place, or
// releases it and reallocates it.
// Depends on csa_pkg, csa_req_if, csa_rsp_if and csa_draw_pool.
module contiguous_slot_allocator (
  input logic      clk,
  input logic      rst,
  csa_req_if.sink  req,
  csa_rsp_if.source rsp
);
  import csa_pkg::*;

  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_HEAD_RD   = 5'd2;
  localparam logic [4:0] S_HEAD_EV   = 5'd3;
  localparam logic [4:0] S_REL       = 5'd4;
  localparam logic [4:0] S_GIVE      = 5'd5;
  localparam logic [4:0] S_TRIM_RD   = 5'd6;
  localparam logic [4:0] S_TRIM_EV   = 5'd7;
  localparam logic [4:0] S_SHRINK    = 5'd8;
  localparam logic [4:0] S_EXT_RD    = 5'd9;
  localparam logic [4:0] S_EXT_EV    = 5'd10;
  localparam logic [4:0] S_EXT_WR    = 5'd11;
  localparam logic [4:0] S_FIND_INIT = 5'd12;
  localparam logic [4:0] S_FIND_RD   = 5'd13;
  localparam logic [4:0] S_FIND_EV   = 5'd14;
  localparam logic [4:0] S_TAKE      = 5'd15;
  localparam logic [4:0] S_TAKE_WAIT = 5'd16;
  localparam logic [4:0] S_MARK      = 5'd17;
  localparam logic [4:0] S_DONE      = 5'd18;

  logic [4:0]        state, state_next;
  logic [END_W-1:0]  idx, idx_next;
  logic [NEED_W-1:0] found, found_next;
  logic [SLOT_W-1:0] head, head_next;
  logic [END_W-1:0]  hwe, hwe_next;
  logic [LEN_W-1:0]  old, old_next;
  logic [NEED_W-1:0] nn, nn_next;
  logic [1:0]        op, op_next;
  logic              pool, pool_next;
  logic [SLOT_W-1:0] start, start_next;
  logic [DRAW_W-1:0] dri, dri_next;
  logic              reloc_pend, reloc_pend_next;
  logic [1:0]        status_r, status_next;
  logic [SLOT_W-1:0] slot_r, slot_next;
  logic [DRAW_W-1:0] draw_r, draw_next;
  logic              reloc_r, reloc_next;

  logic              out_valid, out_valid_next;
  logic [1:0]        o_status;
  logic [SLOT_W-1:0] o_slot;
  logic [DRAW_W-1:0] o_draw;
  logic              o_reloc;
  logic [END_W-1:0]  o_end;
  logic [CNT_W-1:0]  o_total;
  logic              load_out;

  slot_ent_t         slot_mem [NUM_SLOTS];
  slot_ent_t         mem_rdata, mem_wdata;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;

  pool_cmd_t                 pcmd;
  logic [1:0]                pavail;
  logic [DRAW_W-1:0]         ptake;
  logic [1:0][CNT_W-1:0]     ptotal;

  logic [END_W-1:0]  addr_off, start_end, head_end, hwe_m1;
  logic [NEED_W-1:0] req_need, req_units;

  csa_draw_pool u_pool (
    .clk       (clk),
    .rst       (rst),
    .cmd       (pcmd),
    .avail     (pavail),
    .take_data (ptake),
    .total     (ptotal)
  );

  assign addr_off  = {1'b0, start} + idx;
  assign start_end = {1'b0, start} + {{(END_W-NEED_W){1'b0}}, nn};
  assign head_end  = {1'b0, head} + {{(END_W-NEED_W){1'b0}}, nn};
  assign hwe_m1    = hwe - 1'b1;

  // ceil(vertex_count / vertices per slot), at least one slot
  assign req_units = {1'b0, req.vertex_count[VC_W-1:VPS_SHIFT]}
                   + {{(NEED_W-1){1'b0}}, |req.vertex_count[VPS_SHIFT-1:0]};
  assign req_need  = (req_units == '0) ? {{(NEED_W-1){1'b0}}, 1'b1} : req_units;

  assign req.ready = (state == S_IDLE);
  assign load_out  = (state == S_DONE) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= slot_mem[mem_raddr];
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    found_next      = found;
    head_next       = head;
    hwe_next        = hwe;
    old_next        = old;
    nn_next         = nn;
    op_next         = op;
    pool_next       = pool;
    start_next      = start;
    dri_next        = dri;
    reloc_pend_next = reloc_pend;
    status_next     = status_r;
    slot_next       = slot_r;
    draw_next       = draw_r;
    reloc_next      = reloc_r;
    mem_we          = 1'b0;
    mem_waddr       = addr_off[SLOT_W-1:0];
    mem_wdata       = '0;
    mem_raddr       = addr_off[SLOT_W-1:0];
    pcmd            = '0;
    pcmd.pool       = pool;
    pcmd.data       = dri;

    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[SLOT_W-1:0];
        idx_next  = idx + 1'b1;
        if (idx == NUM_SLOTS - 1'b1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          op_next         = req.op;
          pool_next       = req.pool;
          start_next      = req.start_slot;
          dri_next        = req.draw_index;
          nn_next         = req_need;
          reloc_pend_next = 1'b0;
          status_next     = ST_OK;
          slot_next       = '0;
          draw_next       = '0;
          reloc_next      = 1'b0;
          case (req.op)
            OP_ALLOC:            state_next = S_FIND_INIT;
            OP_FREE, OP_UPDATE:  state_next = S_HEAD_RD;
            default:             state_next = S_DONE;
          endcase
        end
      end
      S_HEAD_RD: begin
        mem_raddr  = start;
        state_next = S_HEAD_EV;
      end
      S_HEAD_EV: begin
        old_next = mem_rdata.len;
        idx_next = '0;
        if (op == OP_FREE) begin
          state_next = (mem_rdata.len != '0) ? S_REL : S_GIVE;
        end else if (nn < {1'b0, mem_rdata.len}) begin
          idx_next   = {{(END_W-NEED_W){1'b0}}, nn};
          state_next = S_SHRINK;
        end else if (nn > {1'b0, mem_rdata.len}) begin
          if (nn > MAX_RUN_SLOTS) begin
            reloc_pend_next = 1'b1;
            state_next      = (mem_rdata.len != '0) ? S_REL : S_GIVE;
          end else begin
            idx_next   = {{(END_W-LEN_W){1'b0}}, mem_rdata.len};
            state_next = S_EXT_RD;
          end
        end else begin
          slot_next  = start;
          draw_next  = dri;
          state_next = S_DONE;
        end
      end
      S_REL: begin
        if (idx < {{(END_W-LEN_W){1'b0}}, old} && addr_off < NUM_SLOTS) begin
          mem_we   = 1'b1;
          idx_next = idx + 1'b1;
        end else begin
          state_next = S_GIVE;
        end
      end
      S_GIVE: begin
        pcmd.give  = 1'b1;
        state_next = S_TRIM_RD;
      end
      S_TRIM_RD: begin
        mem_raddr = hwe_m1[SLOT_W-1:0];
        if (hwe == '0) begin
          idx_next   = '0;
          found_next = '0;
          state_next = reloc_pend ? S_FIND_INIT : S_DONE;
        end else begin
          state_next = S_TRIM_EV;
        end
      end
      S_TRIM_EV: begin
        if (mem_rdata.used) begin
          state_next = reloc_pend ? S_FIND_INIT : S_DONE;
        end else begin
          hwe_next   = hwe_m1;
          state_next = S_TRIM_RD;
        end
      end
      S_SHRINK: begin
        if (idx < {{(END_W-LEN_W){1'b0}}, old} && addr_off < NUM_SLOTS) begin
          mem_we   = 1'b1;
          idx_next = idx + 1'b1;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = start;
          mem_wdata.used = 1'b1;
          mem_wdata.len  = nn[LEN_W-1:0];
          slot_next      = start;
          draw_next      = dri;
          state_next     = S_TRIM_RD;
        end
      end
      S_EXT_RD: begin
        if (idx == {{(END_W-NEED_W){1'b0}}, nn}) begin
          idx_next   = {{(END_W-LEN_W){1'b0}}, old};
          state_next = S_EXT_WR;
        end else if (addr_off >= NUM_SLOTS) begin
          reloc_pend_next = 1'b1;
          idx_next        = '0;
          state_next      = (old != '0) ? S_REL : S_GIVE;
        end else begin
          state_next = S_EXT_EV;
        end
      end
      S_EXT_EV: begin
        if (mem_rdata.used) begin
          reloc_pend_next = 1'b1;
          idx_next        = '0;
          state_next      = (old != '0) ? S_REL : S_GIVE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_EXT_RD;
        end
      end
      S_EXT_WR: begin
        mem_we = 1'b1;
        if (idx < {{(END_W-NEED_W){1'b0}}, nn}) begin
          mem_wdata.used = 1'b1;
          idx_next       = idx + 1'b1;
        end else begin
          mem_waddr      = start;
          mem_wdata.used = 1'b1;
          mem_wdata.len  = nn[LEN_W-1:0];
          if (start_end > hwe) hwe_next = start_end;
          slot_next      = start;
          draw_next      = dri;
          state_next     = S_DONE;
        end
      end
      S_FIND_INIT: begin
        idx_next   = '0;
        found_next = '0;
        if (nn > MAX_RUN_SLOTS) begin
          status_next = ST_NO_SPACE;
          state_next  = S_DONE;
        end else begin
          state_next = S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        mem_raddr = idx[SLOT_W-1:0];
        if (idx == NUM_SLOTS) begin
          status_next = ST_NO_SPACE;
          state_next  = S_DONE;
        end else begin
          state_next = S_FIND_EV;
        end
      end
      S_FIND_EV: begin
        idx_next   = idx + 1'b1;
        state_next = S_FIND_RD;
        if (mem_rdata.used) begin
          found_next = '0;
        end else begin
          if (found == '0) head_next = idx[SLOT_W-1:0];
          found_next = found + 1'b1;
          if (found + 1'b1 == nn) state_next = S_TAKE;
        end
      end
      S_TAKE: begin
        if (pavail[pool]) begin
          pcmd.take  = 1'b1;
          state_next = S_TAKE_WAIT;
        end else begin
          status_next = ST_NO_DRAW;
          state_next  = S_DONE;
        end
      end
      S_TAKE_WAIT: begin
        draw_next  = ptake;
        idx_next   = '0;
        state_next = S_MARK;
      end
      S_MARK: begin
        mem_waddr = head + idx[SLOT_W-1:0];
        if (idx < {{(END_W-NEED_W){1'b0}}, nn}) begin
          mem_we         = 1'b1;
          mem_wdata.used = 1'b1;
          mem_wdata.len  = (idx == '0) ? nn[LEN_W-1:0] : '0;
          idx_next       = idx + 1'b1;
        end else begin
          if (head_end > hwe) hwe_next = head_end;
          slot_next  = head;
          reloc_next = reloc_pend;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    out_valid_next = out_valid;
    if (load_out) out_valid_next = 1'b1;
    else if (rsp.ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      hwe        <= '0;
      reloc_pend <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      hwe        <= hwe_next;
      reloc_pend <= reloc_pend_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    found    <= found_next;
    head     <= head_next;
    old      <= old_next;
    nn       <= nn_next;
    op       <= op_next;
    pool     <= pool_next;
    start    <= start_next;
    dri      <= dri_next;
    status_r <= status_next;
    slot_r   <= slot_next;
    draw_r   <= draw_next;
    reloc_r  <= reloc_next;
    if (load_out) begin
      o_status <= status_r;
      o_slot   <= slot_r;
      o_draw   <= draw_r;
      o_reloc  <= reloc_r;
      o_end    <= hwe;
      o_total  <= ptotal[pool];
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = o_status;
  assign rsp.slot_out   = o_slot;
  assign rsp.draw_out   = o_draw;
  assign rsp.relocated  = o_reloc;
  assign rsp.used_end   = o_end;
  assign rsp.draw_total = o_total;

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req.ready)
    else $error("request taken during table clear");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (rsp.valid && state == S_IDLE))
    else $error("finished result not presented");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |->
      (rsp.slot_out == '0 && rsp.draw_out == '0 && !rsp.relocated))
    else $error("failed request returned a held slot");

  a_end_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.used_end <= NUM_SLOTS))
    else $error("used end beyond pool");

endmodule
